// ===== hw/rtl/spfr_pkg.sv =====
// Shared types and constants for the slot pool with free-slot reuse.
package spfr_pkg;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;
	localparam int IDX_W    = 6;
	localparam int VALUE_W  = 32;
	localparam int LIVE_W   = 7;

	// free marks are stored eight to a memory row
	localparam int ROW_W  = 8;
	localparam int ROW_LW = 3;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ROW_W-1:0]    row_t;

	localparam op_t OP_ADD    = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_GET    = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_FREE  = 2'd3;

endpackage

// ===== hw/rtl/slot_pool_with_free_reuse_unit.sv =====
// Slot pool with free marks: add into lowest freed slot or append, remove by slot, get by rank.
//
// One command is worked at a time. Values live in a POOL_SLOTS x ELEMENT_WIDTH
// memory, free marks in a second memory of eight-bit rows; both have a
// registered read. An append or a remove is a read-modify-write of one free row:
// the row is read from S_IDLE and updated in S_RMW, then S_DONE loads the
// result register and the sequencer returns to S_IDLE for the next input
// transfer. A command rejected up front (bad op, remove past the used length,
// get past the live count, pool full) goes from S_IDLE straight to S_DONE to
// load its result. An add that reuses a freed slot, and a get, scan the free
// rows from row 0 at one row per cycle, up to the row that holds the slot; a
// get then reads the value in S_VAL before S_DONE loads its result. The row
// scan is what sets the rate. A result that waits for m_tready holds the
// sequencer once the next command has been worked. Marks at or above the used
// length are treated as zero, so no clearing pass runs after reset. A new
// command is taken while the previous result still waits in the output
// register.
module slot_pool_with_free_reuse_unit
	import spfr_pkg::*;
#(
	parameter int POOL_SLOTS    = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [5:0] slot_index, [37:6] value, [39:38] zero
	input  logic [7:0]  s_tuser,   // [1:0] op, [7:2] zero
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [5:0] slot, [37:6] read_value, [44:38] live_count, rest zero
	output logic [7:0]  m_tuser    // [1:0] status, [7:2] zero
);

	localparam int SW       = $clog2(POOL_SLOTS);
	localparam int CW       = $clog2(POOL_SLOTS + 1);
	localparam int NUM_ROWS = (POOL_SLOTS + ROW_W - 1) / ROW_W;
	localparam int RW       = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int XW0      = (CW > RW + ROW_LW) ? CW : RW + ROW_LW;
	localparam int XW       = (XW0 > IDX_W) ? XW0 : IDX_W;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RMW  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_VAL  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	// control and working registers
	logic [2:0]             state_q, state_d;
	logic [CW-1:0]          used_q, used_d;     // slots ever taken
	logic [CW-1:0]          freed_q, freed_d;   // slots marked free
	op_t                    op_q;
	logic [IDX_W-1:0]       idx_q;
	logic [VALUE_W-1:0]     val_q;
	logic [RW-1:0]          row_q, row_d;       // next row to read in a scan
	logic [RW-1:0]          rd_row_s1, rd_row_d; // row whose data is on the read port
	logic [CW-1:0]          rank_q, rank_d;     // live slots before rd_row_s1
	status_t                res_status_q, res_status_d;
	logic [SW-1:0]          res_slot_q, res_slot_d;
	logic [ELEMENT_WIDTH-1:0] res_val_q, res_val_d;

	// input field views
	op_t              in_op;
	logic [IDX_W-1:0] in_idx;
	logic [VALUE_W-1:0] in_value;
	logic             in_xfer;

	assign in_op    = s_tuser[1:0];
	assign in_idx   = s_tdata[5:0];
	assign in_value = s_tdata[37:6];
	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;

	// output register
	logic                   m_tvalid_q;
	status_t                out_status_q;
	logic [IDX_W-1:0]       out_slot_q;
	logic [VALUE_W-1:0]     out_val_q;
	logic [LIVE_W-1:0]      out_live_q;
	logic                   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_live_q, out_val_q, out_slot_q};
	assign m_tuser  = {6'b000000, out_status_q};

	// free-mark memory
	row_t             free_mem [NUM_ROWS];
	row_t             free_rd_s1;
	logic [RW-1:0]    fr_raddr;
	logic             fr_we;
	logic [RW-1:0]    fr_waddr;
	row_t             fr_wdata;

	always_ff @(posedge clk) begin
		if (fr_we) begin
			free_mem[fr_waddr] <= fr_wdata;
		end
		free_rd_s1 <= free_mem[fr_raddr];
	end

	// value memory
	logic [ELEMENT_WIDTH-1:0] val_mem [POOL_SLOTS];
	logic [ELEMENT_WIDTH-1:0] va_rd_s1;
	logic [SW-1:0]            va_raddr;
	logic                     va_we;
	logic [SW-1:0]            va_waddr;
	logic [ELEMENT_WIDTH-1:0] va_wdata;

	always_ff @(posedge clk) begin
		if (va_we) begin
			val_mem[va_waddr] <= va_wdata;
		end
		va_rd_s1 <= val_mem[va_raddr];
	end

	// row decode: marks past the used length count as neither free nor live
	row_t             row_valid;
	row_t             free_word;
	row_t             live_word;
	logic             ff_any;
	logic [ROW_LW-1:0] ff_bit;
	logic [ROW_LW:0]  live_cnt;
	logic [ROW_LW-1:0] sel_j;
	logic [ROW_LW-1:0] sel_bit;
	logic             hit;

	always_comb begin
		logic [ROW_LW:0] c;
		row_valid = '0;
		for (int b = 0; b < ROW_W; b++) begin
			row_valid[b] = XW'({rd_row_s1, ROW_LW'(b)}) < XW'(used_q);
		end
		free_word = free_rd_s1 & row_valid;
		live_word = ~free_rd_s1 & row_valid;

		// lowest free mark
		ff_any = 1'b0;
		ff_bit = '0;
		for (int b = ROW_W - 1; b >= 0; b--) begin
			if (free_word[b]) begin
				ff_any = 1'b1;
				ff_bit = ROW_LW'(b);
			end
		end

		// rank select within the row
		sel_j   = ROW_LW'(XW'(idx_q) - XW'(rank_q));
		sel_bit = '0;
		c       = '0;
		for (int b = 0; b < ROW_W; b++) begin
			if (live_word[b] && (c == {1'b0, sel_j})) begin
				sel_bit = ROW_LW'(b);
			end
			c = c + {{ROW_LW{1'b0}}, live_word[b]};
		end
		live_cnt = c;
		hit      = (XW'(rank_q) + XW'(live_cnt)) > XW'(idx_q);
	end

	// sequencer
	always_comb begin
		logic [RW-1:0] start_row;
		logic [SW-1:0] ff_slot;
		logic [SW-1:0] sel_slot;
		ff_slot  = SW'({rd_row_s1, ff_bit});
		sel_slot = SW'({rd_row_s1, sel_bit});

		state_d      = state_q;
		used_d       = used_q;
		freed_d      = freed_q;
		row_d        = row_q;
		rd_row_d     = rd_row_s1;
		rank_d       = rank_q;
		res_status_d = res_status_q;
		res_slot_d   = res_slot_q;
		res_val_d    = res_val_q;
		fr_raddr     = row_q;
		fr_we        = 1'b0;
		fr_waddr     = rd_row_s1;
		fr_wdata     = free_word;
		va_we        = 1'b0;
		va_waddr     = SW'(used_q);
		va_wdata     = ELEMENT_WIDTH'(val_q);
		va_raddr     = sel_slot;

		// first row to read: append row, remove row, or row 0 for a scan
		if (in_op == OP_REMOVE) begin
			start_row = RW'(XW'(in_idx) >> ROW_LW);
		end else if (in_op == OP_ADD && freed_q == '0) begin
			start_row = RW'(used_q >> ROW_LW);
		end else begin
			start_row = '0;
		end

		unique case (state_q)
			S_IDLE: begin
				fr_raddr = start_row;
				if (in_xfer) begin
					rd_row_d     = start_row;
					row_d        = start_row + RW'(1);
					rank_d       = '0;
					res_status_d = ST_OK;
					res_slot_d   = '0;
					res_val_d    = '0;
					priority if (in_op == OP_ADD) begin
						if (freed_q != '0) begin
							state_d = S_SCAN;
						end else if (used_q == CW'(POOL_SLOTS)) begin
							res_status_d = ST_FULL;
							state_d      = S_DONE;
						end else begin
							// append: value goes in now, free row cleaned next cycle
							va_we    = 1'b1;
							va_waddr = SW'(used_q);
							va_wdata = ELEMENT_WIDTH'(in_value);
							state_d  = S_RMW;
						end
					end else if (in_op == OP_REMOVE) begin
						if (XW'(in_idx) >= XW'(used_q)) begin
							res_status_d = ST_RANGE;
							state_d      = S_DONE;
						end else begin
							state_d = S_RMW;
						end
					end else if (in_op == OP_GET) begin
						if (XW'(in_idx) >= XW'(used_q - freed_q)) begin
							res_status_d = ST_RANGE;
							state_d      = S_DONE;
						end else begin
							state_d = S_SCAN;
						end
					end else begin
						res_status_d = ST_RANGE;
						state_d      = S_DONE;
					end
				end
			end
			S_RMW: begin
				if (op_q == OP_ADD) begin
					// masking drops the stale mark of the appended slot
					fr_we      = 1'b1;
					fr_wdata   = free_word;
					used_d     = used_q + CW'(1);
					res_slot_d = SW'(used_q);
				end else if (free_word[idx_q[ROW_LW-1:0]]) begin
					res_status_d = ST_FREE;
				end else begin
					fr_we    = 1'b1;
					fr_wdata = free_word | (row_t'(1) << idx_q[ROW_LW-1:0]);
					freed_d  = freed_q + CW'(1);
				end
				state_d = S_DONE;
			end
			S_SCAN: begin
				row_d    = row_q + RW'(1);
				rd_row_d = row_q;
				if (op_q == OP_ADD) begin
					if (ff_any) begin
						fr_we      = 1'b1;
						fr_wdata   = free_word & ~(row_t'(1) << ff_bit);
						va_we      = 1'b1;
						va_waddr   = ff_slot;
						va_wdata   = ELEMENT_WIDTH'(val_q);
						freed_d    = freed_q - CW'(1);
						res_slot_d = ff_slot;
						state_d    = S_DONE;
					end
				end else if (hit) begin
					res_slot_d = sel_slot;
					state_d    = S_VAL;
				end else begin
					rank_d = rank_q + CW'(live_cnt);
				end
			end
			S_VAL: begin
				res_val_d = va_rd_s1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			used_q     <= '0;
			freed_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			freed_q <= freed_d;
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= in_op;
			idx_q <= in_idx;
			val_q <= in_value;
		end
		row_q        <= row_d;
		rd_row_s1    <= rd_row_d;
		rank_q       <= rank_d;
		res_status_q <= res_status_d;
		res_slot_q   <= res_slot_d;
		res_val_q    <= res_val_d;
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_slot_q   <= IDX_W'(res_slot_q);
			out_val_q    <= VALUE_W'(res_val_q);
			out_live_q   <= LIVE_W'(used_q - freed_q);
		end
	end

`ifndef NO_ASSERTIONS
	a_freed_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		freed_q <= used_q)
		else $error("freed count exceeds used length");

	a_used_le_pool: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(POOL_SLOTS))
		else $error("used length exceeds pool size");

	a_full_only_when_used_up: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1:0] == ST_FULL) |-> used_q == CW'(POOL_SLOTS))
		else $error("full reported with slots left");

	a_reuse_scan_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && op_q == OP_ADD) |-> freed_q != '0)
		else $error("reuse scan with no freed slot");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q != S_IDLE)
		else $error("sequencer idle right after input transfer");
`endif

endmodule

// ===== verif/tb_slot_pool_with_free_reuse_unit.sv =====
// Testbench for the slot pool unit: directed table plus random traffic against a predictor.
module tb_slot_pool_with_free_reuse_unit
	import spfr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_N        = 64;
	localparam int RANDOM_ITEMS  = 1570;
	localparam int PHASE_LEN     = 80;     // items per fill or drain phase
	localparam int HOLD_CYCLES   = 250;    // long receiver hold-off
	localparam int DRAIN_CYCLES  = 24;     // extra wait after the last expected result
	localparam int CYCLE_LIMIT   = 400000;
	localparam op_t OP_SPARE     = 2'd3;   // unused op code, must be rejected

	// one result transfer, unpacked from m_tdata / m_tuser
	typedef struct packed {
		status_t               status;
		logic [IDX_W-1:0]      slot;
		logic [VALUE_W-1:0]    rd;
		logic [LIVE_W-1:0]     live;
	} pool_result_t;

	// one directed row; typed rows carry a hand-written result
	typedef struct {
		op_t                op;
		logic [IDX_W-1:0]   idx;
		logic [VALUE_W-1:0] val;
		int                 reps;
		bit                 rnd_val;
		bit                 typed;
		pool_result_t       res;
	} stim_row_t;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [39:0]        s_tdata  = '0;
	logic [7:0]         s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [47:0]        m_tdata;
	logic [7:0]         m_tuser;

	// predictor copy of the pool
	logic [VALUE_W-1:0] slot_data [POOL_N];
	bit                 free_mark [POOL_N] = '{default: 1'b0};
	int                 used_len  = 0;
	int                 freed_cnt = 0;

	// expectations enter at the front and leave at the back
	pool_result_t       pending_results [$];
	int                 mismatch_count = 0;
	int                 cycle_count    = 0;
	bit                 steady         = 1'b0;   // no idling on either side
	bit                 stall_request  = 1'b0;   // ask receiver for a long hold-off

	stim_row_t plan [24] = '{
		// empty pool: every lookup is out of range
		'{OP_GET,    6'd0,  32'h0,        1, 0, 1, '{ST_RANGE, 6'd0,  32'h0,        7'd0}},
		'{OP_REMOVE, 6'd0,  32'h0,        1, 0, 1, '{ST_RANGE, 6'd0,  32'h0,        7'd0}},
		'{OP_SPARE,  6'd63, 32'hffffffff, 1, 0, 1, '{ST_RANGE, 6'd0,  32'h0,        7'd0}},
		// appends, get by rank, remove and double remove
		'{OP_ADD,    6'd0,  32'h0,        1, 0, 1, '{ST_OK,    6'd0,  32'h0,        7'd1}},
		'{OP_ADD,    6'd63, 32'hffffffff, 1, 0, 1, '{ST_OK,    6'd1,  32'h0,        7'd2}},
		'{OP_GET,    6'd1,  32'h0,        1, 0, 1, '{ST_OK,    6'd1,  32'hffffffff, 7'd2}},
		'{OP_REMOVE, 6'd0,  32'h0,        1, 0, 1, '{ST_OK,    6'd0,  32'h0,        7'd1}},
		'{OP_REMOVE, 6'd0,  32'h0,        1, 0, 1, '{ST_FREE,  6'd0,  32'h0,        7'd1}},
		'{OP_GET,    6'd0,  32'h0,        1, 0, 1, '{ST_OK,    6'd1,  32'hffffffff, 7'd1}},
		// add reuses the freed slot 0
		'{OP_ADD,    6'd0,  32'h12345678, 1, 0, 1, '{ST_OK,    6'd0,  32'h0,        7'd2}},
		'{OP_REMOVE, 6'd63, 32'h0,        1, 0, 1, '{ST_RANGE, 6'd0,  32'h0,        7'd2}},
		'{OP_GET,    6'd63, 32'h0,        1, 0, 1, '{ST_RANGE, 6'd0,  32'h0,        7'd2}},
		'{OP_GET,    6'd2,  32'h0,        1, 0, 1, '{ST_RANGE, 6'd0,  32'h0,        7'd2}},
		// fill the rest of the pool, then hit full
		'{OP_ADD,    6'd0,  32'h0,       62, 1, 0, '{ST_OK,    6'd0,  32'h0,        7'd0}},
		'{OP_ADD,    6'd0,  32'hdeadbeef, 1, 0, 1, '{ST_FULL,  6'd0,  32'h0,        7'd64}},
		'{OP_GET,    6'd63, 32'h0,        1, 0, 0, '{ST_OK,    6'd0,  32'h0,        7'd0}},
		'{OP_GET,    6'd0,  32'h0,        1, 0, 1, '{ST_OK,    6'd0,  32'h12345678, 7'd64}},
		// free top and a middle slot, reuse lowest first
		'{OP_REMOVE, 6'd63, 32'h0,        1, 0, 1, '{ST_OK,    6'd0,  32'h0,        7'd63}},
		'{OP_REMOVE, 6'd5,  32'h0,        1, 0, 1, '{ST_OK,    6'd0,  32'h0,        7'd62}},
		'{OP_REMOVE, 6'd63, 32'h0,        1, 0, 1, '{ST_FREE,  6'd0,  32'h0,        7'd62}},
		'{OP_ADD,    6'd0,  32'haaaaaaaa, 1, 0, 1, '{ST_OK,    6'd5,  32'h0,        7'd63}},
		'{OP_ADD,    6'd0,  32'h55555555, 1, 0, 1, '{ST_OK,    6'd63, 32'h0,        7'd64}},
		'{OP_ADD,    6'd0,  32'h0,        1, 0, 1, '{ST_FULL,  6'd0,  32'h0,        7'd64}},
		'{OP_GET,    6'd63, 32'h0,        1, 0, 1, '{ST_OK,    6'd63, 32'h55555555, 7'd64}}
	};

	slot_pool_with_free_reuse_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Applies one command to the predictor state and returns the result it must produce.
	function automatic pool_result_t pool_apply(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [VALUE_W-1:0] val);
		pool_result_t r;
		bit           hit;
		int           rank;
		r    = '{ST_OK, '0, '0, '0};
		hit  = 1'b0;
		rank = 0;
		case (op)
			OP_ADD: begin
				// lowest freed slot wins over an append
				for (int k = 0; k < used_len; k++) begin
					if (free_mark[k] && !hit) begin
						slot_data[k] = val;
						free_mark[k] = 1'b0;
						freed_cnt--;
						r.slot = IDX_W'(k);
						hit = 1'b1;
					end
				end
				if (!hit) begin
					if (used_len < POOL_N) begin
						slot_data[used_len] = val;
						free_mark[used_len] = 1'b0;
						r.slot = IDX_W'(used_len);
						used_len++;
					end else begin
						r.status = ST_FULL;
					end
				end
			end
			OP_REMOVE: begin
				if (idx >= used_len) begin
					r.status = ST_RANGE;
				end else if (free_mark[idx]) begin
					r.status = ST_FREE;
				end else begin
					free_mark[idx] = 1'b1;
					freed_cnt++;
				end
			end
			OP_GET: begin
				// rank counts live slots only, in slot order
				for (int k = 0; k < used_len; k++) begin
					if (!free_mark[k] && !hit) begin
						if (rank == idx) begin
							r.slot = IDX_W'(k);
							r.rd = slot_data[k];
							hit = 1'b1;
						end
						rank++;
					end
				end
				if (!hit)
					r.status = ST_RANGE;
			end
			default: begin
				r.status = ST_RANGE;
			end
		endcase
		r.live = LIVE_W'(used_len - freed_cnt);
		return r;
	endfunction

	// Offers one command; entered and left just after a falling edge.
	// The expectation is queued at the edge where the transfer happens.
	task automatic offer(input op_t op, input logic [IDX_W-1:0] idx,
			input logic [VALUE_W-1:0] val, input bit typed, input pool_result_t typed_res);
		pool_result_t r;
		while (!steady && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, val, idx};
		s_tuser  <= {6'b0, op};
		do @(posedge clk); while (!s_tready);
		r = pool_apply(op, idx, val);
		pending_results.push_front(typed ? typed_res : r);
		@(negedge clk);
	endtask

	// Random command shaped by phase: fill phases favor adds, drain phases favor
	// removes of live slots, so the pool swings between empty and full.
	task automatic pick_command(input bit filling, output op_t op,
			output logic [IDX_W-1:0] idx, output logic [VALUE_W-1:0] val);
		int roll;
		int pick;
		int live;
		int rank;
		int add_cut;
		roll    = $urandom_range(99);
		pick    = $urandom_range(9);
		live    = used_len - freed_cnt;
		add_cut = filling ? 60 : 25;
		val     = $urandom;
		idx     = IDX_W'($urandom_range(POOL_N - 1));
		if (roll < 4) begin
			op = OP_SPARE;
		end else if (roll < add_cut) begin
			op = OP_ADD;
		end else if (roll < add_cut + (filling ? 15 : 45)) begin
			op = OP_REMOVE;
			if (pick < 6 && live > 0) begin
				// hit a live slot, found by rank
				rank = $urandom_range(live - 1);
				for (int k = 0; k < used_len; k++) begin
					if (!free_mark[k]) begin
						if (rank == 0)
							idx = IDX_W'(k);
						rank--;
					end
				end
			end else if (pick < 9 && used_len > 0) begin
				idx = IDX_W'($urandom_range(used_len - 1));   // often an already free slot
			end
		end else begin
			op = OP_GET;
			if (pick < 8 && live > 0)
				idx = IDX_W'($urandom_range(live - 1));
			else if (pick == 8)
				idx = IDX_W'(live);   // one past the last live rank
		end
	endtask

	// Receiver: random backpressure, a quiet stretch, and one long hold-off on request.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				stall_request = 1'b0;
			end
			m_tready <= steady || ($urandom_range(99) >= 20);
		end
	end

	// Result checker: every result transfer is matched against the oldest expectation.
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		pool_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result transfer with none expected: data %h user %h",
					$time, m_tdata, m_tuser);
			end else begin
				want = pending_results.pop_back();
				check_field("status",     32'(want.status), 32'(m_tuser[1:0]));
				check_field("slot",       32'(want.slot),   32'(m_tdata[5:0]));
				check_field("read_value", want.rd,          m_tdata[37:6]);
				check_field("live_count", 32'(want.live),   32'(m_tdata[44:38]));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random traffic, drain, verdict.
	initial begin
		op_t                op;
		logic [IDX_W-1:0]   idx;
		logic [VALUE_W-1:0] val;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			for (int r = 0; r < plan[i].reps; r++) begin
				val = plan[i].rnd_val ? $urandom : plan[i].val;
				offer(plan[i].op, plan[i].idx, val, plan[i].typed, plan[i].res);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// long hold-off on the result side while commands keep coming
			if (n == 300)
				stall_request = 1'b1;
			steady = (n >= 700 && n < 950);
			pick_command(((n / PHASE_LEN) % 2) == 0, op, idx, val);
			offer(op, idx, val, 1'b0, '{ST_OK, '0, '0, '0});
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
